>>> sv/fcd_pkg.sv
// shared types and constants for the fractional comb delay
// no dependencies
`timescale 1ns / 1ps

package fcd_pkg;

    localparam int SMP_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int DELAY_W    = 21;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 8'd3;

    localparam logic [DELAY_W-1:0] DELAY_MIN = 21'd256;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 16'd62259;
    localparam logic [MIX_W-1:0]   MIX_ONE   = 17'd65536;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_len;
        logic [GAIN_W-1:0]  feedback_gain;
        logic [GAIN_W-1:0]  damping;
        logic [MIX_W-1:0]   wet_mix;
    } t_cfg;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [35:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 36'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -36'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/fcd_ifs.sv
// stream and configuration channel interfaces
// depends on fcd_pkg
`timescale 1ns / 1ps

interface fcd_in_if;
    import fcd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fcd_out_if;
    import fcd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface fcd_cfg_if;
    import fcd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/fcd_cfg.sv
// configuration register file with range clamping on write
// depends on fcd_pkg and fcd_cfg_if
`timescale 1ns / 1ps

module fcd_cfg #(
    parameter int DLY_SAMPLES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcd_cfg_if.sink       i_cfg,
    output fcd_pkg::t_cfg o_cfg
);
    import fcd_pkg::*;

    localparam logic [31:0] DELAY_HI = 32'(DLY_SAMPLES * 256);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [DELAY_W-1:0] wr_delay;
    logic [GAIN_W-1:0]  wr_gain;
    logic [MIX_W-1:0]   wr_mix;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        wr_delay = i_cfg.data[DELAY_W-1:0];
        wr_gain  = i_cfg.data[GAIN_W-1:0];
        wr_mix   = i_cfg.data[MIX_W-1:0];
        if (wr_delay < DELAY_MIN) begin
            wr_delay = DELAY_MIN;
        end else if (32'(wr_delay) > DELAY_HI) begin
            wr_delay = DELAY_W'(DELAY_HI);
        end
        if (wr_gain > GAIN_MAX) begin
            wr_gain = GAIN_MAX;
        end
        if (wr_mix > MIX_ONE) begin
            wr_mix = MIX_ONE;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DELAY_LEN:     n_cfg.delay_len     = wr_delay;
                REG_FEEDBACK_GAIN: n_cfg.feedback_gain = wr_gain;
                REG_DAMPING:       n_cfg.damping       = wr_gain;
                REG_WET_MIX:       n_cfg.wet_mix       = wr_mix;
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_len     <= DELAY_MIN;
            r_cfg.feedback_gain <= '0;
            r_cfg.damping       <= '0;
            r_cfg.wet_mix       <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.delay_len >= DELAY_MIN && 32'(r_cfg.delay_len) <= DELAY_HI)
        else $error("delay length out of range");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.feedback_gain <= GAIN_MAX && r_cfg.damping <= GAIN_MAX)
        else $error("gain out of range");

    a_unknown_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.index != REG_DELAY_LEN && i_cfg.index != REG_FEEDBACK_GAIN
         && i_cfg.index != REG_DAMPING && i_cfg.index != REG_WET_MIX) |=> $stable(r_cfg))
        else $error("unknown register index changed configuration");

endmodule

>>> sv/fcd_ring.sv
// delay ring memory, one read port with registered data and one write port
// entries beyond the fill count read as zero; depends on fcd_pkg
`timescale 1ns / 1ps

module fcd_ring #(
    parameter int DEPTH = 4098
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic signed [fcd_pkg::SMP_W-1:0] o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic signed [fcd_pkg::SMP_W-1:0] i_wr_data
);
    import fcd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] FULL = (AW + 1)'(DEPTH);

    logic signed [SMP_W-1:0] mem [DEPTH];
    logic signed [SMP_W-1:0] r_rd_data;
    logic                    r_rd_ok;
    logic [AW:0]             r_fill;
    logic [AW:0]             n_fill;

    // writes come in address order from zero, so the fill count marks written entries
    always_comb begin
        n_fill = r_fill;
        if (i_wr_en && r_fill != FULL) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_rd_en) begin
                r_rd_ok <= {1'b0, i_rd_addr} < r_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count beyond depth");

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && r_fill != FULL) |-> {1'b0, i_wr_addr} == r_fill)
        else $error("ring written out of order while filling");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr_en |=> $stable(r_fill))
        else $error("fill count moved without a write");

endmodule

>>> sv/fractional_comb_delay.sv
// damped feedback comb filter with a fractional, linearly interpolated delay
// depends on fcd_pkg, fcd_ifs, fcd_cfg and fcd_ring
//
// usage:
//   i_smp carries one Q1.15 input sample per transaction, o_smp one mixed
//   Q1.15 output sample per input. i_cfg writes the registers delay_len (0),
//   feedback_gain (1), damping (2) and wet_mix (3); values are clamped to
//   range and other indexes are ignored. i_cfg is always ready; the user must
//   keep it written only while the block is idle; the block does not enforce it.
//   an item goes through RD0, RD1, SUM, DAMP, LP and FB to its result in the
//   output register; a new item is taken only in idle. the sequence is set
//   by the ring's single read port (two neighboring reads per item) followed
//   by the chain of interpolation, damping, feedback and mix multiplies.
//   reset restores the register defaults, clears the write position and the
//   damping state; the ring reads as zero wherever it was not yet written,
//   tracked by a fill count, so no clearing pass is needed.
//   the output register lets the next item be accepted while a result waits;
//   if it is still held when the next result is ready, that item waits before
//   its ring write until the receiver takes the pending transaction.
`timescale 1ns / 1ps

module fractional_comb_delay #(
    parameter int DLY_SAMPLES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcd_in_if.sink    i_smp,
    fcd_out_if.source o_smp,
    fcd_cfg_if.sink   i_cfg
);
    import fcd_pkg::*;

    localparam int RING_LEN = DLY_SAMPLES + 2;
    localparam int AW       = $clog2(RING_LEN);
    localparam int DW       = AW + 8;
    localparam int PW       = DW + 1;
    localparam logic [PW-1:0] RING_SPAN = PW'(RING_LEN * 256);
    localparam logic [AW-1:0] LAST_POS  = AW'(RING_LEN - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD0  = 7'b0000010,
        S_RD1  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_DAMP = 7'b0010000,
        S_LP   = 7'b0100000,
        S_FB   = 7'b1000000
    } t_state;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic [AW-1:0]           r_wpos;
    logic signed [SMP_W-1:0] r_damp;
    logic signed [SMP_W-1:0] r_x;
    logic [AW-1:0]           r_i1;
    logic [7:0]              r_frac;
    logic signed [SMP_W-1:0] r_b0;
    logic signed [25:0]      r_p0;
    logic signed [25:0]      r_p1;
    logic signed [SMP_W-1:0] r_delayed;
    logic signed [33:0]      r_dprod;
    logic signed [33:0]      r_mix0;
    logic signed [33:0]      r_mix1;
    logic signed [SMP_W-1:0] r_out;
    logic                    r_ovalid;

    logic                    accept;
    logic                    fire;
    logic [PW-1:0]           pos_raw;
    logic [PW-1:0]           pos;
    logic [AW-1:0]           i0;
    logic [AW-1:0]           i1;
    logic [7:0]              frac;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [SMP_W-1:0] rd_data;
    logic [8:0]              w0;
    logic signed [26:0]      isum;
    logic signed [26:0]      irnd;
    logic signed [16:0]      diff;
    logic [MIX_W-1:0]        dry;
    logic signed [33:0]      drnd;
    logic signed [32:0]      fbp;
    logic signed [32:0]      fbr;
    logic signed [35:0]      msum;
    logic signed [35:0]      mrnd;
    logic signed [SMP_W-1:0] wr_data;

    fcd_cfg #(.DLY_SAMPLES(DLY_SAMPLES)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fcd_ring #(.DEPTH(RING_LEN)) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (fire),
        .i_wr_addr (r_wpos),
        .i_wr_data (wr_data)
    );

    assign i_smp.ready      = (r_state == S_IDLE);
    assign accept           = i_smp.valid && (r_state == S_IDLE);
    assign fire             = (r_state == S_FB) && (!r_ovalid || o_smp.ready);
    assign o_smp.valid      = r_ovalid;
    assign o_smp.sample_out = r_out;

    // read position behind the write position, wrapped round the ring
    always_comb begin
        pos_raw = {1'b0, r_wpos, 8'b0} - {1'b0, DW'(cfg.delay_len)};
        pos     = pos_raw[PW-1] ? pos_raw + RING_SPAN : pos_raw;
        i0      = pos[DW-1:8];
        frac    = pos[7:0];
        i1      = (i0 == LAST_POS) ? '0 : i0 + AW'(1);
        rd_en   = accept || (r_state == S_RD0);
        rd_addr = (r_state == S_RD0) ? r_i1 : i0;
    end

    always_comb begin
        w0      = 9'd256 - {1'b0, r_frac};
        isum    = 27'(r_p0) + 27'(r_p1);
        irnd    = (isum + 27'sd128) >>> 8;
        diff    = 17'(r_damp) - 17'(r_delayed);
        dry     = MIX_ONE - cfg.wet_mix;
        drnd    = (r_dprod + 34'sd32768) >>> 16;
        fbp     = $signed({1'b0, cfg.feedback_gain}) * r_damp;
        fbr     = (fbp + 33'sd32768) >>> 16;
        wr_data = sat16(36'(fbr) + 36'(r_x));
        msum    = 36'(r_mix0) + 36'(r_mix1);
        mrnd    = (msum + 36'sd32768) >>> 16;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_SUM;
            S_SUM:   n_state = S_DAMP;
            S_DAMP:  n_state = S_LP;
            S_LP:    n_state = S_FB;
            S_FB:    if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wpos   <= '0;
            r_damp   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LP) begin
                r_damp <= sat16(36'(r_delayed) + 36'(drnd));
            end
            if (fire) begin
                r_wpos   <= (r_wpos == LAST_POS) ? '0 : r_wpos + AW'(1);
                r_ovalid <= 1'b1;
            end else if (o_smp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= i_smp.sample_in;
            r_i1   <= i1;
            r_frac <= frac;
        end
        if (r_state == S_RD0) begin
            r_b0 <= rd_data;
        end
        if (r_state == S_RD1) begin
            r_p0 <= r_b0 * $signed({1'b0, w0});
            r_p1 <= rd_data * $signed({2'b0, r_frac});
        end
        if (r_state == S_SUM) begin
            r_delayed <= sat16(36'(irnd));
        end
        if (r_state == S_DAMP) begin
            r_dprod <= $signed({1'b0, cfg.damping}) * diff;
            r_mix0  <= r_x * $signed({1'b0, dry});
        end
        if (r_state == S_LP) begin
            r_mix1 <= r_delayed * $signed({1'b0, cfg.wet_mix});
        end
        if (fire) begin
            r_out <= sat16(mrnd);
        end
    end

    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= LAST_POS)
        else $error("write position outside the ring");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_smp.ready) |=> $stable(r_out))
        else $error("pending result overwritten");

    a_wpos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FB) |=> $stable(r_wpos))
        else $error("write position moved outside the write step");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_state == S_IDLE) && r_ovalid)
        else $error("ring write did not complete the item");

endmodule
